// File: rtl/kts_pkg.sv
// Package for the topological sort engine: field widths, parameter defaults,
// command and status codes. Depends on nothing.
package kts_pkg;

  localparam int NODE_W        = 6;
  localparam int CNT_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// File: rtl/kahn_topological_sort.sv
// Kahn topological sort engine over an insertion-ordered edge memory; uses kts_pkg.
// Add edge: the result is registered from S_RESP, after S_ADD2 writes the reverse edge when undirected.
// Run: S_CLR clears in-degrees, S_CNT counts them, S_SEED seeds the ready queue, then per node
// emitted (queue read, edge scan, result), over the stored edges and the live nodes.
// One item at a time: the next item is taken when the previous one's work is done.
// Reset clears control, edge count and node count (64); memories are not cleared.
module kahn_topological_sort #(
  parameter int MAX_NODES = kts_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = kts_pkg::MAX_EDGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [kts_pkg::NODE_W-1:0]     in_src_node,
  input  logic [kts_pkg::NODE_W-1:0]     in_dst_node,
  input  logic                           in_directed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [kts_pkg::NODE_W-1:0]     out_node_id,
  output logic                           out_node_valid,
  output logic                           out_last,
  output logic                           out_cycle_found,
  output logic [kts_pkg::STATUS_W-1:0]   out_status,
  input  logic                           cfg_we,
  input  logic [kts_pkg::CNT_W-1:0]      cfg_wdata
);
  import kts_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int DGW = ETW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD2 = 4'd1;
  localparam logic [3:0] S_RESP = 4'd2;
  localparam logic [3:0] S_CLR  = 4'd3;
  localparam logic [3:0] S_CNT  = 4'd4;
  localparam logic [3:0] S_SEED = 4'd5;
  localparam logic [3:0] S_POP  = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;

  logic [3:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    node_count_r;
  logic [ETW-1:0]      etotal_r, etotal_nxt;
  logic [NCW-1:0]      head_r, head_nxt;
  logic [NCW-1:0]      tail_r, tail_nxt;
  logic                s1_v_r, s1_v_nxt;
  logic                s2_v_r, s2_v_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [NCW-1:0]      idx_r, idx_nxt;
  logic [ETW-1:0]      eidx_r, eidx_nxt;
  logic [NAW-1:0]      s2_addr_r, s2_addr_nxt;
  logic [NODE_W-1:0]   src_r, src_nxt;
  logic [NODE_W-1:0]   dst_r, dst_nxt;
  logic [NODE_W-1:0]   rsp_node_r, rsp_node_nxt;
  logic                rsp_nv_r, rsp_nv_nxt;
  logic                rsp_last_r, rsp_last_nxt;
  logic                rsp_cyc_r, rsp_cyc_nxt;
  logic [STATUS_W-1:0] rsp_status_r, rsp_status_nxt;
  logic [NODE_W-1:0]   out_node_r, out_node_nxt;
  logic                out_nv_r, out_nv_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_cyc_r, out_cyc_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [2*NODE_W-1:0] edge_mem [MAX_EDGES];
  logic [DGW-1:0]      deg_mem [MAX_NODES];
  logic [NODE_W-1:0]   rq_mem [MAX_NODES];

  logic                e_we;
  logic [EAW-1:0]      e_wa, e_ra;
  logic [2*NODE_W-1:0] e_wd, e_q;
  logic                d_we, d_re;
  logic [NAW-1:0]      d_wa, d_ra;
  logic [DGW-1:0]      d_wd, d_q;
  logic                d_fwd_r;
  logic [DGW-1:0]      d_fwd_d_r;
  logic                q_we, q_re;
  logic [NAW-1:0]      q_wa, q_ra;
  logic [NODE_W-1:0]   q_wd, q_q;

  logic [NCW-1:0]      eff_n;
  logic [NODE_W-1:0]   e_src, e_dst;
  logic                dst_in, src_in, edge_go;
  logic [DGW-1:0]      deg_val;
  logic                bad_range, store_full;

  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_wa] <= e_wd;
    end
    e_q <= edge_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      deg_mem[d_wa] <= d_wd;
    end
    d_q       <= deg_mem[d_ra];
    d_fwd_r   <= d_we && d_re && (d_wa == d_ra);
    d_fwd_d_r <= d_wd;
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      rq_mem[q_wa] <= q_wd;
    end
    if (q_re) begin
      q_q <= rq_mem[q_ra];
    end
  end

  assign eff_n = (node_count_r > CNT_W'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                    : node_count_r[NCW-1:0];
  assign e_src   = e_q[2*NODE_W-1:NODE_W];
  assign e_dst   = e_q[NODE_W-1:0];
  assign src_in  = CNT_W'(e_src) < CNT_W'(eff_n);
  assign dst_in  = CNT_W'(e_dst) < CNT_W'(eff_n);
  assign edge_go = eidx_r < etotal_r;
  assign deg_val = d_fwd_r ? d_fwd_d_r : d_q;

  assign bad_range  = (CNT_W'(in_src_node) >= CNT_W'(eff_n)) ||
                      (CNT_W'(in_dst_node) >= CNT_W'(eff_n));
  assign store_full = in_directed ? (etotal_r == ETW'(MAX_EDGES))
                                  : (etotal_r >= ETW'(MAX_EDGES - 1));

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_node_id     = out_node_r;
  assign out_node_valid  = out_nv_r;
  assign out_last        = out_last_r;
  assign out_cycle_found = out_cyc_r;
  assign out_status      = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    etotal_nxt     = etotal_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    s1_v_nxt       = 1'b0;
    s2_v_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    idx_nxt        = idx_r;
    eidx_nxt       = eidx_r;
    s2_addr_nxt    = s2_addr_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    rsp_node_nxt   = rsp_node_r;
    rsp_nv_nxt     = rsp_nv_r;
    rsp_last_nxt   = rsp_last_r;
    rsp_cyc_nxt    = rsp_cyc_r;
    rsp_status_nxt = rsp_status_r;
    out_node_nxt   = out_node_r;
    out_nv_nxt     = out_nv_r;
    out_last_nxt   = out_last_r;
    out_cyc_nxt    = out_cyc_r;
    out_status_nxt = out_status_r;
    e_we           = 1'b0;
    e_wa           = etotal_r[EAW-1:0];
    e_wd           = {dst_r, src_r};
    e_ra           = eidx_r[EAW-1:0];
    d_we           = 1'b0;
    d_wa           = s2_addr_r;
    d_wd           = '0;
    d_re           = 1'b0;
    d_ra           = idx_r[NAW-1:0];
    q_we           = 1'b0;
    q_wa           = tail_r[NAW-1:0];
    q_wd           = NODE_W'(s2_addr_r);
    q_re           = 1'b0;
    q_ra           = head_r[NAW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_RUN: begin
              idx_nxt   = '0;
              state_nxt = S_CLR;
            end
            CMD_ADD: begin
              src_nxt      = in_src_node;
              dst_nxt      = in_dst_node;
              rsp_node_nxt = '0;
              rsp_nv_nxt   = 1'b0;
              rsp_last_nxt = 1'b1;
              rsp_cyc_nxt  = 1'b0;
              state_nxt    = S_RESP;
              if (bad_range) begin
                rsp_status_nxt = ST_RANGE;
              end else if (store_full) begin
                rsp_status_nxt = ST_FULL;
              end else begin
                rsp_status_nxt = ST_OK;
                e_we           = 1'b1;
                e_wd           = {in_src_node, in_dst_node};
                etotal_nxt     = etotal_r + ETW'(1);
                if (!in_directed) begin
                  state_nxt = S_ADD2;
                end
              end
            end
          endcase
        end
      end
      S_ADD2: begin
        e_we       = 1'b1;
        e_wd       = {dst_r, src_r};
        etotal_nxt = etotal_r + ETW'(1);
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = rsp_node_r;
          out_nv_nxt     = rsp_nv_r;
          out_last_nxt   = rsp_last_r;
          out_cyc_nxt    = rsp_cyc_r;
          out_status_nxt = rsp_status_r;
          state_nxt      = rsp_last_r ? S_IDLE : S_POP;
        end
      end
      S_CLR: begin
        if (idx_r < eff_n) begin
          d_we    = 1'b1;
          d_wa    = idx_r[NAW-1:0];
          idx_nxt = idx_r + NCW'(1);
        end else begin
          eidx_nxt  = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if (edge_go) begin
          s1_v_nxt = 1'b1;
          eidx_nxt = eidx_r + ETW'(1);
        end
        if (s1_v_r && src_in && dst_in) begin
          d_re        = 1'b1;
          d_ra        = e_dst[NAW-1:0];
          s2_v_nxt    = 1'b1;
          s2_addr_nxt = e_dst[NAW-1:0];
        end
        if (s2_v_r) begin
          d_we = 1'b1;
          d_wd = deg_val + DGW'(1);
        end
        if (!edge_go && !s1_v_r && !s2_v_r) begin
          idx_nxt   = '0;
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        if (idx_r < eff_n) begin
          d_re        = 1'b1;
          s2_v_nxt    = 1'b1;
          s2_addr_nxt = idx_r[NAW-1:0];
          idx_nxt     = idx_r + NCW'(1);
        end
        if (s2_v_r && deg_val == '0) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + NCW'(1);
        end
        if (!(idx_r < eff_n) && !s2_v_r) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (head_r == tail_r) begin
          rsp_node_nxt   = '0;
          rsp_nv_nxt     = 1'b0;
          rsp_last_nxt   = 1'b1;
          rsp_cyc_nxt    = head_r < eff_n;
          rsp_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else begin
          q_re      = 1'b1;
          head_nxt  = head_r + NCW'(1);
          eidx_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (edge_go) begin
          s1_v_nxt = 1'b1;
          eidx_nxt = eidx_r + ETW'(1);
        end
        if (s1_v_r && (e_src == q_q) && dst_in) begin
          d_re        = 1'b1;
          d_ra        = e_dst[NAW-1:0];
          s2_v_nxt    = 1'b1;
          s2_addr_nxt = e_dst[NAW-1:0];
        end
        if (s2_v_r && deg_val != '0) begin
          d_we = 1'b1;
          d_wd = deg_val - DGW'(1);
          if (deg_val == DGW'(1) && tail_r < NCW'(MAX_NODES)) begin
            q_we     = 1'b1;
            tail_nxt = tail_r + NCW'(1);
          end
        end
        if (!edge_go && !s1_v_r && !s2_v_r) begin
          rsp_node_nxt   = q_q;
          rsp_nv_nxt     = 1'b1;
          rsp_last_nxt   = (head_r == tail_r);
          rsp_cyc_nxt    = (head_r == tail_r) && (head_r < eff_n);
          rsp_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      etotal_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      etotal_r    <= etotal_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    eidx_r       <= eidx_nxt;
    s2_addr_r    <= s2_addr_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    rsp_node_r   <= rsp_node_nxt;
    rsp_nv_r     <= rsp_nv_nxt;
    rsp_last_r   <= rsp_last_nxt;
    rsp_cyc_r    <= rsp_cyc_nxt;
    rsp_status_r <= rsp_status_nxt;
    out_node_r   <= out_node_nxt;
    out_nv_r     <= out_nv_nxt;
    out_last_r   <= out_last_nxt;
    out_cyc_r    <= out_cyc_nxt;
    out_status_r <= out_status_nxt;
  end

  // The ready queue never pops past what was pushed.
  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_edges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    etotal_r <= ETW'(MAX_EDGES))
    else $error("edge count exceeds store depth");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_nv_r |-> out_last_r)
    else $error("item without a node is not marked last");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before the first finished");

  a_stage2_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (state_r == S_CNT || state_r == S_SEED || state_r == S_SCAN))
    else $error("in-degree update pending outside a memory pass");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for kahn_topological_sort: random edge and sort items
// are checked against an in-bench Kahn ordering predictor. Depends on kts_pkg.
`timescale 1ns / 100ps

module testbench;
  import kts_pkg::*;

  localparam int MAX_N = MAX_NODES_DEF;
  localparam int MAX_E = MAX_EDGES_DEF;

  typedef struct packed {
    logic                command;
    logic [NODE_W-1:0]   src_node;
    logic [NODE_W-1:0]   dst_node;
    logic                directed;
  } sort_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node_id;
    logic                node_valid;
    logic                last;
    logic                cycle_found;
    logic [STATUS_W-1:0] status;
  } order_entry_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = CMD_ADD;
  logic [NODE_W-1:0]   in_src_node = '0;
  logic [NODE_W-1:0]   in_dst_node = '0;
  logic                in_directed = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [NODE_W-1:0]   out_node_id;
  logic                out_node_valid;
  logic                out_last;
  logic                out_cycle_found;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_we = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  sort_cmd_t         pending_q[$];
  order_entry_t      order_q[$];
  logic [NODE_W-1:0] arc_from[MAX_E];
  logic [NODE_W-1:0] arc_to[MAX_E];
  int unsigned       arc_total = 0;
  logic [CNT_W-1:0]  count_model = NODE_COUNT_RST;

  bit           in_taken = 1'b0;
  bit           out_taken = 1'b0;
  bit           calm_in = 1'b0;
  bit           calm_out = 1'b0;
  int unsigned  idle_left = 0;
  int unsigned  stall_left = 0;
  sort_cmd_t    seen_cmd;
  order_entry_t want;

  int mismatches = 0;
  int items_taken = 0;
  int runs_taken = 0;
  int results_checked = 0;
  int cycles_flagged = 0;
  int edges_refused = 0;
  int settings_used = 0;

  kahn_topological_sort i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_src_node     (in_src_node),
    .in_dst_node     (in_dst_node),
    .in_directed     (in_directed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node_id     (out_node_id),
    .out_node_valid  (out_node_valid),
    .out_last        (out_last),
    .out_cycle_found (out_cycle_found),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned live_nodes(input logic [CNT_W-1:0] count);
    return (count > MAX_N) ? MAX_N : count;
  endfunction

  function automatic order_entry_t order_entry(input int unsigned node, input bit valid,
                                               input bit last, input bit cyc,
                                               input logic [STATUS_W-1:0] status);
    order_entry_t r;
    r.node_id = NODE_W'(node);
    r.node_valid = valid;
    r.last = last;
    r.cycle_found = cyc;
    r.status = status;
    return r;
  endfunction

  function automatic void predict_order(input int unsigned n);
    int unsigned  indeg[MAX_N];
    int unsigned  fifo[MAX_N];
    int unsigned  head;
    int unsigned  tail;
    int unsigned  node;
    int unsigned  dst;
    int unsigned  emitted;
    order_entry_t closing;
    head = 0;
    tail = 0;
    emitted = 0;
    for (int i = 0; i < n; i++) indeg[i] = 0;
    for (int e = 0; e < arc_total; e++)
      if (arc_from[e] < n && arc_to[e] < n) indeg[arc_to[e]]++;
    for (int i = 0; i < n; i++) begin
      if (indeg[i] == 0) begin
        fifo[tail] = i;
        tail++;
      end
    end
    while (head < tail) begin
      node = fifo[head];
      head++;
      order_q = {order_q, order_entry(node, 1'b1, 1'b0, 1'b0, ST_OK)};
      emitted++;
      for (int e = 0; e < arc_total; e++) begin
        dst = arc_to[e];
        if (arc_from[e] == node && dst < n && indeg[dst] > 0) begin
          indeg[dst]--;
          if (indeg[dst] == 0) begin
            fifo[tail] = dst;
            tail++;
          end
        end
      end
    end
    if (emitted == 0) begin
      order_q = {order_q, order_entry(0, 1'b0, 1'b1, n > 0, ST_OK)};
    end else begin
      closing = order_q.pop_back();
      closing.last = 1'b1;
      closing.cycle_found = emitted < n;
      order_q = {order_q, closing};
    end
  endfunction

  function automatic void predict_item(input sort_cmd_t c);
    int unsigned n;
    int unsigned slots;
    n = live_nodes(count_model);
    slots = c.directed ? 1 : 2;
    if (c.command == CMD_RUN) begin
      predict_order(n);
    end else if (c.src_node >= n || c.dst_node >= n) begin
      order_q = {order_q, order_entry(0, 1'b0, 1'b1, 1'b0, ST_RANGE)};
    end else if (MAX_E - arc_total < slots) begin
      order_q = {order_q, order_entry(0, 1'b0, 1'b1, 1'b0, ST_FULL)};
    end else begin
      arc_from[arc_total] = c.src_node;
      arc_to[arc_total] = c.dst_node;
      arc_total++;
      if (!c.directed) begin
        arc_from[arc_total] = c.dst_node;
        arc_to[arc_total] = c.src_node;
        arc_total++;
      end
      order_q = {order_q, order_entry(0, 1'b0, 1'b1, 1'b0, ST_OK)};
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] expected,
                                      input logic [7:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endfunction

  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void queue_edge(input int unsigned src, input int unsigned dst,
                                     input bit directed);
    sort_cmd_t c;
    c.command = CMD_ADD;
    c.src_node = NODE_W'(src);
    c.dst_node = NODE_W'(dst);
    c.directed = directed;
    pending_q = {pending_q, c};
  endfunction

  function automatic void queue_run();
    sort_cmd_t c;
    c.command = CMD_RUN;
    c.src_node = NODE_W'($urandom_range(0, 63));
    c.dst_node = NODE_W'($urandom_range(0, 63));
    c.directed = 1'($urandom_range(0, 1));
    pending_q = {pending_q, c};
  endfunction

  task automatic settle();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || order_q.size() != 0);
  endtask

  task automatic set_node_count(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    count_model = value;
    settings_used++;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) idle_left = draw_gap(calm_in);
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (pending_q.size() > 0) begin
        seen_cmd = pending_q.pop_front();
        in_command <= seen_cmd.command;
        in_src_node <= seen_cmd.src_node;
        in_dst_node <= seen_cmd.dst_node;
        in_directed <= seen_cmd.directed;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_taken) stall_left = draw_gap(calm_out);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        if (out_valid) stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      items_taken++;
      if (in_command == CMD_RUN) runs_taken++;
      predict_item('{in_command, in_src_node, in_dst_node, in_directed});
    end
    if (rst_n && out_valid && out_ready) begin
      if (order_q.size() == 0) begin
        $error("Result with nothing expected: node_id %0d, status %0d", out_node_id,
               out_status);
        mismatches++;
      end else begin
        want = order_q.pop_front();
        check_field("node_id", 8'(want.node_id), 8'(out_node_id));
        check_field("node_valid", 8'(want.node_valid), 8'(out_node_valid));
        check_field("last", 8'(want.last), 8'(out_last));
        check_field("cycle_found", 8'(want.cycle_found), 8'(out_cycle_found));
        check_field("status", 8'(want.status), 8'(out_status));
        results_checked++;
        if (want.last && want.cycle_found) cycles_flagged++;
        if (want.status != ST_OK) edges_refused++;
      end
    end
  end

  initial begin
    int unsigned      span;
    int unsigned      slots;
    int unsigned      batch;
    int unsigned      done_random;
    int unsigned      phase_idx;
    int unsigned      pick;
    int unsigned      a;
    int unsigned      b;
    logic [CNT_W-1:0] setting;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The reset node count applies to the first batch.
    queue_run();
    queue_edge(63, 0, 1'b1);
    queue_edge(62, 63, 1'b0);
    queue_edge(0, 63, 1'b1);
    queue_run();
    settle();

    set_node_count(7'd0);
    queue_edge(0, 0, 1'b1);
    queue_edge(0, 0, 1'b0);
    queue_run();
    settle();

    set_node_count(7'd127);
    queue_edge(63, 61, 1'b1);
    queue_run();
    settle();

    // Edges stored earlier name nodes above the count and must be ignored.
    set_node_count(7'd1);
    queue_edge(0, 63, 1'b0);
    queue_edge(1, 0, 1'b1);
    queue_run();
    settle();

    set_node_count(7'd3);
    queue_edge(2, 0, 1'b1);
    queue_edge(2, 1, 1'b1);
    queue_run();
    settle();

    phase_idx = 0;
    done_random = 0;
    while (done_random < 30) begin
      case (phase_idx)
        0: setting = 7'd64;
        1: setting = 7'd16;
        2: setting = 7'd127;
        3: setting = 7'd8;
        4: setting = 7'd2;
        5: setting = 7'd40;
        6: setting = 7'd65;
        7: setting = 7'd24;
        default: setting = CNT_W'($urandom_range(0, 127));
      endcase
      set_node_count(setting);
      span = live_nodes(setting);
      batch = $urandom_range(3, 6);
      repeat (batch - 1) begin
        pick = $urandom_range(0, 15);
        if (pick < 2) begin
          queue_run();
        end else if (pick < 11 && span >= 2) begin
          a = $urandom_range(1, span - 1);
          b = $urandom_range(0, a - 1);
          queue_edge(a, b, 1'b1);
        end else if (pick < 13) begin
          queue_edge(48 + $urandom_range(0, 15), 48 + $urandom_range(0, 15), 1'b0);
        end else begin
          queue_edge($urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
        end
      end
      queue_run();
      settle();
      done_random += batch;
      phase_idx++;
    end

    // Fill the edge store to one free slot, then probe the full conditions.
    set_node_count(7'd64);
    slots = MAX_E - 1 - arc_total;
    repeat (slots / 2) begin
      a = $urandom_range(1, 63);
      b = $urandom_range(0, a - 1);
      queue_edge(a, b, 1'b0);
    end
    if (slots % 2 == 1) begin
      queue_edge(5, 4, 1'b1);
    end
    queue_edge(50, 51, 1'b0);
    queue_edge(63, 63, 1'b1);
    queue_edge(0, 1, 1'b1);
    queue_run();
    settle();

    set_node_count(7'd10);
    queue_edge(20, 3, 1'b1);
    queue_edge(2, 3, 1'b1);
    queue_run();
    settle();

    set_node_count(7'd0);
    queue_run();
    settle();

    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d items (%0d sorts, %0d with a cycle).",
             results_checked, items_taken, runs_taken, cycles_flagged);
    $display("Node count written %0d times; %0d edges refused; %0d edge slots in use.",
             settings_used, edges_refused, arc_total);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timed out with %0d results still expected.", order_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: kahn_topological_sort.f
rtl/kts_pkg.sv
rtl/kahn_topological_sort.sv
dv/testbench.sv
